// File: rtl/drrip_stream_deadblock_replacement_defines.svh
// ---------------------------------------------------------------------------
// DRRIP replacement engine - assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef DRRIP_STREAM_DEADBLOCK_REPLACEMENT_DEFINES_SVH
`define DRRIP_STREAM_DEADBLOCK_REPLACEMENT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DSDR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsdr assertion failed");

// next-cycle implication, disabled in reset
`define DSDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsdr assertion failed");

`endif

// File: rtl/dsdr_pkg.sv
// ---------------------------------------------------------------------------
// DRRIP replacement engine - package
// Sizes, codes and shared types.
// ---------------------------------------------------------------------------
package dsdr_pkg;

   localparam int SETS              = 2048;
   localparam int WAYS              = 16;
   localparam int SELECTOR_BITS     = 10;
   localparam int DECAY_PERIOD_LOG2 = 12;

   localparam int SET_BITS  = $clog2(SETS);
   localparam int WAY_BITS  = $clog2(WAYS);
   localparam int AGE_BITS  = 2;
   localparam int ADDR_BITS = 64;
   localparam int DRAW_BITS = 5;
   localparam int CNT_BITS  = 2;
   localparam int CSR_BITS  = 12;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [AGE_BITS-1:0] AGE_MAX  = 2'd3;
   localparam logic [AGE_BITS-1:0] AGE_NEAR = 2'd2;
   localparam logic [AGE_BITS-1:0] AGE_HIT  = 2'd0;
   localparam logic [CNT_BITS-1:0] CNT_MAX  = 2'd3;

   localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
   localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;
   localparam logic [DECAY_PERIOD_LOG2-1:0] DECAY_LAST = '1;
   localparam logic [CSR_BITS-1:0] LEADERS_RESET = 12'd32;
   localparam logic [SET_BITS-1:0] SET_LAST = SET_BITS'(SETS - 1);

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SRRIP_LEADERS = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BRRIP_LEADERS = 1'd1;

   typedef logic [WAYS-1:0][AGE_BITS-1:0] age_row_type;
   typedef logic [WAYS-1:0]               dead_row_type;

   typedef struct packed {
      logic                  valid;
      logic [CNT_BITS-1:0]   count;
      logic [ADDR_BITS-1:0]  addr;
   } stream_row_type;

   typedef enum logic [1:0] {
      ST_SWEEP_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP_DEAD
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic sweep_init;
      logic sweep_dead;
   } cmd_type;

   typedef struct packed {
      logic lookup;
      logic rsp_blocked;
      logic decay_wrap;
      logic sweep_last;
   } status_type;

endpackage

// File: rtl/dsdr_req_if.sv
// ---------------------------------------------------------------------------
// DRRIP replacement engine - request channel
// Valid/ready channel carrying one lookup or update transaction.
// ---------------------------------------------------------------------------
interface dsdr_req_if import dsdr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [SET_BITS-1:0]  set_index;
   logic [WAY_BITS-1:0]  way_index;
   logic [ADDR_BITS-1:0] phys_address;
   logic                 was_hit;
   logic [DRAW_BITS-1:0] chance_draw;

   modport source (output valid, func, set_index, way_index, phys_address, was_hit,
                   chance_draw, input ready);
   modport sink   (input valid, func, set_index, way_index, phys_address, was_hit,
                   chance_draw, output ready);
endinterface

// File: rtl/dsdr_rsp_if.sv
// ---------------------------------------------------------------------------
// DRRIP replacement engine - response channel
// Valid/ready channel carrying one victim transaction.
// ---------------------------------------------------------------------------
interface dsdr_rsp_if import dsdr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WAY_BITS-1:0] victim_way;
   logic                victim_was_dead;

   modport source (output valid, victim_way, victim_was_dead, input ready);
   modport sink   (input valid, victim_way, victim_was_dead, output ready);
endinterface

// File: rtl/dsdr_ram.sv
// ---------------------------------------------------------------------------
// DRRIP replacement engine - generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dsdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/dsdr_ctrl.sv
// ---------------------------------------------------------------------------
// DRRIP replacement engine - controller
// Sequences clearing passes, transaction accept and execute.
// ---------------------------------------------------------------------------
`include "drrip_stream_deadblock_replacement_defines.svh"

module dsdr_ctrl import dsdr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_SWEEP_INIT: begin
            cmd.sweep_init = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!(status.lookup && status.rsp_blocked)) begin
               cmd.exec = 1'b1;
               if (!status.lookup && status.decay_wrap) state_in = ST_SWEEP_DEAD;
               else                                     state_in = ST_IDLE;
            end
         end
         ST_SWEEP_DEAD: begin
            cmd.sweep_dead = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP_INIT;
      endcase
   end

   `DSDR_ASSERT_SAME(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
   `DSDR_ASSERT_SAME(a_init_after_reset, clock, reset, $past(reset), state_ff == ST_SWEEP_INIT)
   `DSDR_ASSERT_NEXT(a_decay_sweep, clock, reset,
      cmd.exec && !status.lookup && status.decay_wrap, state_ff == ST_SWEEP_DEAD)
   `DSDR_ASSERT_NEXT(a_accept_exec, clock, reset, cmd.accept, !req_ready)
endmodule

// File: rtl/dsdr_dp.sv
// ---------------------------------------------------------------------------
// DRRIP replacement engine - datapath
// Set-row memories, stream detector, dueling selector and result register.
// ---------------------------------------------------------------------------
module dsdr_dp import dsdr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    req_func,
   input  logic [SET_BITS-1:0]     req_set_index,
   input  logic [WAY_BITS-1:0]     req_way_index,
   input  logic [ADDR_BITS-1:0]    req_phys_address,
   input  logic                    req_was_hit,
   input  logic [DRAW_BITS-1:0]    req_chance_draw,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [WAY_BITS-1:0]     rsp_victim_way,
   output logic                    rsp_victim_was_dead,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wr_data
);
   logic                 func_ff;
   logic [SET_BITS-1:0]  set_ff;
   logic [WAY_BITS-1:0]  way_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic                 hit_ff;
   logic [DRAW_BITS-1:0] draw_ff;

   logic [SET_BITS-1:0]          sweep_ff, sweep_in;
   logic [SELECTOR_BITS-1:0]     sel_ff, sel_in;
   logic [DECAY_PERIOD_LOG2-1:0] upd_cnt_ff, upd_cnt_in;
   logic [CSR_BITS-1:0]          srrip_cnt_ff, brrip_cnt_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [WAY_BITS-1:0]          victim_way_ff;
   logic                         victim_dead_ff;

   age_row_type    age_rd, age_wr;
   dead_row_type   dead_rd, dead_wr;
   stream_row_type stream_rd, stream_wr;
   logic           age_we, dead_we, stream_we, sweeping;
   logic [SET_BITS-1:0] wr_addr;

   logic                lookup, miss_upd, dead_any, found_dead, found_age;
   logic                has3, has2, has1, is_s, is_b, brrip_ins;
   logic [WAY_BITS-1:0] dead_way, age_way;
   logic [AGE_BITS-1:0] top, new_age;
   logic [CNT_BITS-1:0] cnt_n;
   logic [CSR_BITS:0]   leader_end;
   age_row_type         aged;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         set_ff  <= req_set_index;
         way_ff  <= req_way_index;
         addr_ff <= req_phys_address;
         hit_ff  <= req_was_hit;
         draw_ff <= req_chance_draw;
      end
      if (cmd.exec && lookup) begin
         victim_way_ff  <= dead_any ? dead_way : age_way;
         victim_dead_ff <= dead_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         sel_ff       <= SEL_MID;
         upd_cnt_ff   <= '0;
         srrip_cnt_ff <= LEADERS_RESET;
         brrip_cnt_ff <= LEADERS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         sel_ff       <= sel_in;
         upd_cnt_ff   <= upd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SRRIP_LEADERS: srrip_cnt_ff <= csr_wr_data;
               CSR_BRRIP_LEADERS: brrip_cnt_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      lookup   = (func_ff == FUNC_LOOKUP);
      miss_upd = !lookup && !hit_ff;
      sweeping = cmd.sweep_init || cmd.sweep_dead;
      sweep_in = sweeping ? sweep_ff + 1'b1 : sweep_ff;

      dead_any   = |dead_rd;
      found_dead = 1'b0;
      dead_way   = '0;
      has3 = 1'b0;
      has2 = 1'b0;
      has1 = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (dead_rd[w] && !found_dead) begin
            dead_way   = WAY_BITS'(w);
            found_dead = 1'b1;
         end
         has3 = has3 || (age_rd[w] == 2'd3);
         has2 = has2 || (age_rd[w] == 2'd2);
         has1 = has1 || (age_rd[w] == 2'd1);
      end
      top = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;
      found_age = 1'b0;
      age_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         aged[w] = age_rd[w] + (AGE_MAX - top);
         if (aged[w] == AGE_MAX && !found_age) begin
            age_way   = WAY_BITS'(w);
            found_age = 1'b1;
         end
      end

      if (!stream_rd.valid)               cnt_n = '0;
      else if (addr_ff > stream_rd.addr)  cnt_n = (stream_rd.count == CNT_MAX) ?
                                                  CNT_MAX : stream_rd.count + 1'b1;
      else                                cnt_n = (stream_rd.count == '0) ?
                                                  '0 : stream_rd.count - 1'b1;

      leader_end = {1'b0, srrip_cnt_ff} + {1'b0, brrip_cnt_ff};
      is_s       = CSR_BITS'(set_ff) < srrip_cnt_ff;
      is_b       = !is_s && ((CSR_BITS + 1)'(set_ff) < leader_end);
      brrip_ins  = (draw_ff != '0);
      if (cnt_n == CNT_MAX)  new_age = AGE_MAX;
      else if (is_s)         new_age = AGE_NEAR;
      else if (is_b)         new_age = brrip_ins ? AGE_MAX : AGE_NEAR;
      else if (sel_ff >= SEL_MID) new_age = AGE_NEAR;
      else                   new_age = brrip_ins ? AGE_MAX : AGE_NEAR;

      sel_in = sel_ff;
      if (cmd.exec && miss_upd) begin
         if (is_s && sel_ff != '0)          sel_in = sel_ff - 1'b1;
         else if (is_b && sel_ff != SEL_MAX) sel_in = sel_ff + 1'b1;
      end
      upd_cnt_in = (cmd.exec && !lookup) ? upd_cnt_ff + 1'b1 : upd_cnt_ff;

      wr_addr = sweeping ? sweep_ff : set_ff;
      age_wr  = age_rd;
      dead_wr = dead_rd;
      if (cmd.sweep_init) begin
         age_wr = {WAYS{AGE_MAX}};
      end else if (lookup) begin
         age_wr = aged;
      end else begin
         age_wr[way_ff]  = hit_ff ? AGE_HIT : new_age;
         dead_wr[way_ff] = !hit_ff;
      end
      if (sweeping) dead_wr = '0;
      stream_wr = cmd.sweep_init ? stream_row_type'('0) :
                  stream_row_type'{valid: 1'b1, count: cnt_n, addr: addr_ff};

      age_we    = cmd.sweep_init || (cmd.exec && !(lookup && dead_any));
      dead_we   = sweeping || (cmd.exec && !lookup);
      stream_we = cmd.sweep_init || (cmd.exec && miss_upd);

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (cmd.exec && lookup);

      status.lookup      = lookup;
      status.rsp_blocked = rsp_valid_ff && !rsp_ready;
      status.decay_wrap  = (upd_cnt_ff == DECAY_LAST);
      status.sweep_last  = (sweep_ff == SET_LAST);
   end

   dsdr_ram #(.WIDTH($bits(age_row_type)), .DEPTH(SETS)) u_age_ram (
      .clock(clock), .wr_en(age_we), .wr_addr(wr_addr), .wr_data(age_wr),
      .rd_en(cmd.accept), .rd_addr(req_set_index), .rd_data(age_rd));

   dsdr_ram #(.WIDTH($bits(dead_row_type)), .DEPTH(SETS)) u_dead_ram (
      .clock(clock), .wr_en(dead_we), .wr_addr(wr_addr), .wr_data(dead_wr),
      .rd_en(cmd.accept), .rd_addr(req_set_index), .rd_data(dead_rd));

   dsdr_ram #(.WIDTH($bits(stream_row_type)), .DEPTH(SETS)) u_stream_ram (
      .clock(clock), .wr_en(stream_we), .wr_addr(wr_addr), .wr_data(stream_wr),
      .rd_en(cmd.accept), .rd_addr(req_set_index), .rd_data(stream_rd));

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_victim_way      = victim_way_ff;
   assign rsp_victim_was_dead = victim_dead_ff;
endmodule

// File: rtl/drrip_stream_deadblock_replacement.sv
// ---------------------------------------------------------------------------
// DRRIP replacement engine - top level
// Dead-mark and stream-aware DRRIP victim selection for a 2048 x 16 cache.
// ---------------------------------------------------------------------------
// Each transaction reads the set row from the age, dead-mark and stream
// memories in the accept state, then modifies and writes it back in the
// execute state. A lookup result sits in an output register, so a new
// transaction is taken while it waits; the engine only holds in execute
// when a second lookup finds that register still full. After reset a
// clearing pass over all 2048 sets initialises the memories, and every 4096
// updates a pass over all sets clears the dead marks; no transaction is
// accepted during either pass. Configuration writes are taken at any time.
module drrip_stream_deadblock_replacement import dsdr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   dsdr_req_if.sink                req_if,
   dsdr_rsp_if.source              rsp_if,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wr_data
);
   cmd_type    cmd;
   status_type status;

   dsdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dsdr_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_if.func),
      .req_set_index       (req_if.set_index),
      .req_way_index       (req_if.way_index),
      .req_phys_address    (req_if.phys_address),
      .req_was_hit         (req_if.was_hit),
      .req_chance_draw     (req_if.chance_draw),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_victim_way      (rsp_if.victim_way),
      .rsp_victim_was_dead (rsp_if.victim_was_dead),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );
endmodule

// File: bench/drrip_stream_deadblock_replacement_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DRRIP replacement engine - testbench
// Drives lookup and update transactions under varying back-pressure,
// predicts every victim from a local model of ages, dead marks, stream
// detectors and the duel selector, and checks each response in order.
// ---------------------------------------------------------------------------
module drrip_stream_deadblock_replacement_tb;
   import dsdr_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int IDLE_LIMIT  = 60000;
   localparam int DRAIN_WAIT  = 16;

   typedef struct {
      logic [WAY_BITS-1:0] way;
      logic                dead;
   } victim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index   = CSR_SRRIP_LEADERS;
   logic [CSR_BITS-1:0]     csr_wr_data = '0;

   dsdr_req_if req_if ();
   dsdr_rsp_if rsp_if ();

   drrip_stream_deadblock_replacement dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // local copy of replacement state
   logic [AGE_BITS-1:0]      age_mem  [SETS*WAYS];
   bit                       dead_mem [SETS*WAYS];
   logic [CNT_BITS-1:0]      rise_cnt [SETS];
   logic [ADDR_BITS-1:0]     fill_addr[SETS];
   bit                       fill_ok  [SETS];
   logic [SELECTOR_BITS-1:0] selector;
   logic [DECAY_PERIOD_LOG2-1:0] decay_cnt;
   int                       srrip_leaders;
   int                       brrip_leaders;

   victim_type victim_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int idle_cycles = 0;
   int pool[8];

   initial begin
      req_if.valid = 1'b0;
      req_if.func = FUNC_LOOKUP;
      req_if.set_index = '0;
      req_if.way_index = '0;
      req_if.phys_address = '0;
      req_if.was_hit = 1'b0;
      req_if.chance_draw = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic void model_reset();
      for (int i = 0; i < SETS*WAYS; i++) begin
         age_mem[i] = AGE_MAX;
         dead_mem[i] = 1'b0;
      end
      for (int i = 0; i < SETS; i++) begin
         rise_cnt[i] = '0;
         fill_addr[i] = '0;
         fill_ok[i] = 1'b0;
      end
      selector = SEL_MID;
      decay_cnt = '0;
      srrip_leaders = 32;
      brrip_leaders = 32;
   endfunction

   function automatic void predict_victim(int s);
      int b;
      logic [AGE_BITS-1:0] top;
      victim_type v;
      bit found;
      b = s * WAYS;
      found = 1'b0;
      v.way = '0;
      v.dead = 1'b0;
      for (int w = 0; w < WAYS; w++)
         if (!found && dead_mem[b+w]) begin
            found = 1'b1;
            v.way = WAY_BITS'(w);
            v.dead = 1'b1;
         end
      if (!found) begin
         top = '0;
         for (int w = 0; w < WAYS; w++)
            if (age_mem[b+w] > top) top = age_mem[b+w];
         for (int w = 0; w < WAYS; w++)
            age_mem[b+w] = age_mem[b+w] + (AGE_MAX - top);
         for (int w = 0; w < WAYS; w++)
            if (!found && age_mem[b+w] == AGE_MAX) begin
               found = 1'b1;
               v.way = WAY_BITS'(w);
            end
      end
      victim_q.push_back(v);
   endfunction

   function automatic void predict_update(int s, int w, logic [ADDR_BITS-1:0] addr,
                                          bit hit, logic [DRAW_BITS-1:0] draw);
      int slot;
      bit is_s;
      bit is_b;
      bit streaming;
      logic [AGE_BITS-1:0] age;
      slot = s * WAYS + w;
      if (hit) begin
         age_mem[slot] = AGE_HIT;
         dead_mem[slot] = 1'b0;
      end else begin
         is_s = s < srrip_leaders;
         is_b = !is_s && s < srrip_leaders + brrip_leaders;
         if (!fill_ok[s]) begin
            fill_ok[s] = 1'b1;
            rise_cnt[s] = '0;
         end else if (addr > fill_addr[s]) begin
            if (rise_cnt[s] < CNT_MAX) rise_cnt[s]++;
         end else begin
            if (rise_cnt[s] > 0) rise_cnt[s]--;
         end
         fill_addr[s] = addr;
         streaming = rise_cnt[s] == CNT_MAX;
         dead_mem[slot] = 1'b1;
         if (streaming) age = AGE_MAX;
         else if (is_s) age = AGE_NEAR;
         else if (is_b || selector < SEL_MID) age = (draw != 0) ? AGE_MAX : AGE_NEAR;
         else age = AGE_NEAR;
         age_mem[slot] = age;
         if (is_s) begin
            if (selector > 0) selector--;
         end else if (is_b) begin
            if (selector < SEL_MAX) selector++;
         end
      end
      decay_cnt = decay_cnt + 1'b1;
      if (decay_cnt == 0)
         for (int i = 0; i < SETS*WAYS; i++) dead_mem[i] = 1'b0;
   endfunction

   task automatic send_item(logic func, int s, int w, logic [ADDR_BITS-1:0] addr,
                            logic hit, logic [DRAW_BITS-1:0] draw);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func <= func;
      req_if.set_index <= SET_BITS'(s);
      req_if.way_index <= WAY_BITS'(w);
      req_if.phys_address <= addr;
      req_if.was_hit <= hit;
      req_if.chance_draw <= draw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (func == FUNC_LOOKUP) predict_victim(s);
      else predict_update(s, w, addr, hit, draw);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      stop_sending();
      while (victim_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, int value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= CSR_BITS'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SRRIP_LEADERS) srrip_leaders = value;
      else brrip_leaders = value;
   endtask

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_random();
      int s;
      int w;
      logic [ADDR_BITS-1:0] addr;
      logic [DRAW_BITS-1:0] draw;
      s = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 7)]
                                       : $urandom_range(0, SETS-1);
      w = $urandom_range(0, WAYS-1);
      addr = ($urandom_range(0, 99) < 60) ? fill_addr[s] + $urandom_range(1, 4096)
                                          : rand_addr();
      draw = ($urandom_range(0, 3) == 0) ? '0 : DRAW_BITS'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 40)
         send_item(FUNC_LOOKUP, s, w, addr, 1'($urandom), draw);
      else send_item(FUNC_UPDATE, s, w, addr, $urandom_range(0, 99) < 35, draw);
   endtask

   task automatic fill_pool();
      for (int i = 0; i < 8; i++)
         case ($urandom_range(0, 3))
            0: pool[i] = $urandom_range(0, 31);
            1: pool[i] = $urandom_range(32, 63);
            default: pool[i] = $urandom_range(0, SETS-1);
         endcase
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_item(FUNC_LOOKUP, 0, 0, '0, 1'b0, '0);
      send_item(FUNC_LOOKUP, SETS-1, 15, '1, 1'b1, 5'd31);
      send_item(FUNC_UPDATE, 100, 5, 64'h0, 1'b0, 5'd31);
      send_item(FUNC_LOOKUP, 100, 0, '0, 1'b0, '0);
      send_item(FUNC_UPDATE, 100, 5, 64'h10, 1'b1, '0);
      send_item(FUNC_LOOKUP, 100, 0, '0, 1'b0, '0);
      send_item(FUNC_UPDATE, 100, 15, '1, 1'b1, '0);
      send_item(FUNC_LOOKUP, 100, 0, '0, 1'b0, '0);
      for (int i = 0; i < 5; i++)
         send_item(FUNC_UPDATE, 200, i, 64'h1000 * (i + 1), 1'b0, 5'd0);
      for (int i = 0; i < 5; i++) send_item(FUNC_UPDATE, 200, i, '0, 1'b1, '0);
      send_item(FUNC_LOOKUP, 200, 0, '0, 1'b0, '0);
      send_item(FUNC_UPDATE, 0, 3, '1, 1'b0, 5'd0);
      send_item(FUNC_UPDATE, 40, 7, '1, 1'b0, 5'd0);
      send_item(FUNC_UPDATE, 41, 8, '0, 1'b0, 5'd17);
      send_item(FUNC_UPDATE, SETS-1, 15, '1, 1'b0, 5'd31);
      send_item(FUNC_LOOKUP, SETS-1, 0, '0, 1'b0, '0);
   endtask

   task automatic test_leader_config();
      int counts[4][2] = '{'{0, 0}, '{2048, 2048}, '{0, 2048}, '{2000, 100}};
      for (int c = 0; c < 4; c++) begin
         write_csr(CSR_SRRIP_LEADERS, counts[c][0]);
         write_csr(CSR_BRRIP_LEADERS, counts[c][1]);
         fill_pool();
         for (int i = 0; i < 60; i++) send_random();
      end
      write_csr(CSR_SRRIP_LEADERS, 32);
      write_csr(CSR_BRRIP_LEADERS, 32);
   endtask

   task automatic test_random_phases();
      int idle_set[4] = '{0, 55, 0, 12};
      int stall_set[4] = '{0, 0, 55, 12};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         fill_pool();
         for (int i = 0; i < 250; i++) send_random();
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_pause_drain();
      stall_pct = 55;
      fill_pool();
      for (int i = 0; i < 40; i++) send_random();
      wait_drained();
      for (int i = 0; i < 40; i++) send_random();
      stall_pct = 0;
   endtask

   task automatic test_decay_wrap();
      int s;
      fill_pool();
      while (decay_cnt != DECAY_LAST) begin
         s = pool[$urandom_range(0, 7)];
         send_item(FUNC_UPDATE, s, $urandom_range(0, WAYS-1), rand_addr(),
                   $urandom_range(0, 3) == 0, DRAW_BITS'($urandom_range(0, 31)));
      end
      send_item(FUNC_UPDATE, pool[0], 2, rand_addr(), 1'b0, 5'd3);
      for (int i = 0; i < 8; i++) send_item(FUNC_LOOKUP, pool[i], 0, '0, 1'b0, '0);
      for (int i = 0; i < 60; i++) send_random();
   endtask

   always @(negedge clock)
      rsp_if.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      victim_type v;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (victim_q.size() == 0) begin
            $display("%0t: unexpected victim way=%0d dead=%0b", $time,
                     rsp_if.victim_way, rsp_if.victim_was_dead);
            errors++;
         end else begin
            v = victim_q.pop_front();
            if (rsp_if.victim_way !== v.way) begin
               $display("%0t: victim_way expected %0d actual %0d", $time, v.way,
                        rsp_if.victim_way);
               errors++;
            end
            if (rsp_if.victim_was_dead !== v.dead) begin
               $display("%0t: victim_was_dead expected %0b actual %0b", $time, v.dead,
                        rsp_if.victim_was_dead);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      model_reset();
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_leader_config();
      test_random_phases();
      test_pause_drain();
      test_decay_wrap();
      wait_drained();
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
